@@ rtl/vsmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsmr_pkg: shared types and constants for the VLAN strip / MAC rewrite block
// Item layouts, header geometry, register indexes and the cell record
// that moves down the header delay line.
// ----------------------------------------------------------------------------
package vsmr_pkg;

   localparam int HDR_BYTES  = 18;
   localparam int OBUF_DEPTH = 2;

   localparam logic [4:0] HDR_LAST_IDX = 5'd17;
   localparam logic [4:0] MAC_END_IDX  = 5'd6;
   localparam logic [4:0] TYPE_HI_IDX  = 5'd12;
   localparam logic [4:0] TYPE_LO_IDX  = 5'd13;
   localparam logic [4:0] TAG_LAST_IDX = 5'd15;

   localparam logic [15:0] TPID_CTAG = 16'h8100;
   localparam logic [15:0] TPID_STAG = 16'h88A8;

   typedef enum logic [1:0] {
      CSR_NEW_DEST_MAC   = 2'd0,
      CSR_DEST_MAC_VALID = 2'd1,
      CSR_EGRESS_PORT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic        verdict;
      logic [15:0] out_port;
   } rsp_type;

   // One byte slot of the delay line. A pending slot belongs to a header
   // whose verdict is not known yet.
   typedef struct packed {
      logic       valid;
      logic       pending;
      logic [4:0] idx;
      logic [7:0] data;
      logic       last;
      logic       verdict;
   } cell_type;

   // Verdict broadcast to every pending slot when a header is decided.
   typedef struct packed {
      logic        apply;
      logic        redirect;
      logic        strip;
      logic [47:0] mac;
   } decide_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       verdict;
   } obuf_entry_type;

   // Byte idx of the MAC, first byte on the wire is the most significant.
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [4:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         5'd0:    b = mac[47:40];
         5'd1:    b = mac[39:32];
         5'd2:    b = mac[31:24];
         5'd3:    b = mac[23:16];
         5'd4:    b = mac[15:8];
         5'd5:    b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

@@ rtl/vsmr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsmr_cell: one byte slot of the header delay line
// Takes the slot behind it (or a bubble) when told to shift, and applies
// a header verdict on the way if the incoming slot is still pending.
// ----------------------------------------------------------------------------
module vsmr_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  shift,
   input  wire                  take,
   input  vsmr_pkg::cell_type   prev_cell,
   input  vsmr_pkg::decide_type dec,
   output vsmr_pkg::cell_type   slot
);

   vsmr_pkg::cell_type cell_ff;
   vsmr_pkg::cell_type cell_in;
   vsmr_pkg::cell_type src;

   always_comb begin
      src     = take ? prev_cell : '0;
      cell_in = src;
      if (dec.apply && src.pending) begin
         cell_in.pending = 1'b0;
         cell_in.verdict = dec.redirect;
         if (dec.strip) begin
            if (src.idx < vsmr_pkg::MAC_END_IDX) begin
               cell_in.data = vsmr_pkg::mac_byte(dec.mac, src.idx);
            end else if (src.idx >= vsmr_pkg::TYPE_HI_IDX &&
                         src.idx <= vsmr_pkg::TAG_LAST_IDX) begin
               // The outer tag is removed by turning its slots into bubbles.
               cell_in.valid = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (shift) begin
         cell_ff <= cell_in;
      end
   end

   assign slot = cell_ff;

endmodule
`default_nettype wire

@@ rtl/vsmr_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsmr_outbuf: two-entry output buffer
// Decouples the result stall from the delay line; full is a register so
// the input stall never depends combinationally on the result stall.
// ----------------------------------------------------------------------------
module vsmr_outbuf (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  vsmr_pkg::obuf_entry_type push_data,
   output logic                     full,
   output logic                     out_valid,
   input  wire                      out_stall,
   output vsmr_pkg::obuf_entry_type out_data
);

   vsmr_pkg::obuf_entry_type mem_ff [vsmr_pkg::OBUF_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !out_stall;
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

@@ rtl/vlan_strip_mac_rewrite.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlan_strip_mac_rewrite: VLAN tag strip with destination MAC rewrite
// Frames pass one byte per item through an 18-slot delay line of cells.
// The header verdict is broadcast to the pending slots when it is known.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_data (in_byte, in_last)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data (out_byte, out_last,
//                                             verdict, out_port)
//   csr_      in         csr_we               csr_index, csr_wdata
//
// One item is accepted per cycle when the output buffer is not full; a body
// byte, or any byte of a frame sent back to back, passes through the 18
// cells of the delay line and then the output buffer to reach the result
// side. Header slots wait in the line until their frame's verdict is known,
// while decided bytes ahead of them keep draining. Reset is synchronous and
// empties the line, the buffer and the frame state. A stall on the result
// side fills the two-entry buffer and then stalls the input.
//
module vlan_strip_mac_rewrite (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  vsmr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output vsmr_pkg::rsp_type  rsp_data,
   input  wire                csr_we,
   input  wire [1:0]          csr_index,
   input  wire [47:0]         csr_wdata
);

   logic [47:0] new_dest_mac_ff;
   logic        dest_mac_valid_ff;
   logic [15:0] egress_port_ff;

   logic [4:0]  hdr_cnt_ff;
   logic [4:0]  hdr_cnt_in;
   logic        in_body_ff;
   logic        in_body_in;
   logic        frame_verdict_ff;
   logic        frame_verdict_in;
   logic [7:0]  type_hi_ff;
   logic [7:0]  type_lo_ff;

   logic                     full;
   logic                     req_fire;
   logic                     decide_now;
   logic                     hdr_full;
   logic                     is_tagged;
   vsmr_pkg::cell_type       new_cell;
   vsmr_pkg::decide_type     dec;
   vsmr_pkg::cell_type       chain [vsmr_pkg::HDR_BYTES];
   vsmr_pkg::obuf_entry_type push_data;
   vsmr_pkg::obuf_entry_type head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         new_dest_mac_ff   <= '0;
         dest_mac_valid_ff <= 1'b0;
         egress_port_ff    <= '0;
      end else if (csr_we) begin
         unique case (vsmr_pkg::csr_index_type'(csr_index))
            vsmr_pkg::CSR_NEW_DEST_MAC:   new_dest_mac_ff   <= csr_wdata;
            vsmr_pkg::CSR_DEST_MAC_VALID: dest_mac_valid_ff <= csr_wdata[0];
            vsmr_pkg::CSR_EGRESS_PORT:    egress_port_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_stall = full;
   assign req_fire  = req_valid && !full;
   assign hdr_full  = (hdr_cnt_ff == vsmr_pkg::HDR_LAST_IDX);
   assign is_tagged = ({type_hi_ff, type_lo_ff} == vsmr_pkg::TPID_CTAG) ||
                      ({type_hi_ff, type_lo_ff} == vsmr_pkg::TPID_STAG);
   assign decide_now = req_fire && !in_body_ff && (req_data.in_last || hdr_full);

   always_comb begin
      new_cell         = '0;
      new_cell.valid   = 1'b1;
      new_cell.data    = req_data.in_byte;
      new_cell.last    = req_data.in_last;
      new_cell.idx     = hdr_cnt_ff;
      new_cell.pending = !in_body_ff;
      new_cell.verdict = frame_verdict_ff;

      // Short frames pass; a full header's type only decides the strip.
      dec.apply    = decide_now;
      dec.redirect = hdr_full && dest_mac_valid_ff;
      dec.strip    = hdr_full && dest_mac_valid_ff && is_tagged;
      dec.mac      = new_dest_mac_ff;

      hdr_cnt_in       = hdr_cnt_ff;
      in_body_in       = in_body_ff;
      frame_verdict_in = frame_verdict_ff;
      if (req_fire) begin
         if (in_body_ff) begin
            if (req_data.in_last) begin
               in_body_in       = 1'b0;
               frame_verdict_in = 1'b0;
            end
         end else if (decide_now) begin
            hdr_cnt_in       = '0;
            in_body_in       = hdr_full && !req_data.in_last;
            frame_verdict_in = hdr_full && !req_data.in_last && dec.redirect;
         end else begin
            hdr_cnt_in = hdr_cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff       <= '0;
         in_body_ff       <= 1'b0;
         frame_verdict_ff <= 1'b0;
      end else begin
         hdr_cnt_ff       <= hdr_cnt_in;
         in_body_ff       <= in_body_in;
         frame_verdict_ff <= frame_verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !in_body_ff && hdr_cnt_ff == vsmr_pkg::TYPE_HI_IDX) begin
         type_hi_ff <= req_data.in_byte;
      end
      if (req_fire && !in_body_ff && hdr_cnt_ff == vsmr_pkg::TYPE_LO_IDX) begin
         type_lo_ff <= req_data.in_byte;
      end
   end

   // Without a new item, only the slots ahead of the pending header move,
   // and the slot just ahead of the header becomes a bubble.
   for (genvar i = 0; i < vsmr_pkg::HDR_BYTES; i++) begin : g_cell
      logic shift;
      logic take;

      assign shift = !full && (req_fire || (5'(i) >= hdr_cnt_ff));
      if (i == 0) begin : g_head
         assign take = req_fire;
         vsmr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .take      (take),
            .prev_cell (new_cell),
            .dec       (dec),
            .slot      (chain[i])
         );
      end else begin : g_body
         assign take = req_fire || (5'(i) > hdr_cnt_ff);
         vsmr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .take      (take),
            .prev_cell (chain[i-1]),
            .dec       (dec),
            .slot      (chain[i])
         );
      end
   end

   assign push_data.data    = chain[vsmr_pkg::HDR_BYTES-1].data;
   assign push_data.last    = chain[vsmr_pkg::HDR_BYTES-1].last;
   assign push_data.verdict = chain[vsmr_pkg::HDR_BYTES-1].verdict;

   vsmr_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (!full && chain[vsmr_pkg::HDR_BYTES-1].valid),
      .push_data (push_data),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_data.out_byte = head.data;
   assign rsp_data.out_last = head.last;
   assign rsp_data.verdict  = head.verdict;
   assign rsp_data.out_port = head.verdict ? egress_port_ff : 16'h0000;

endmodule
`default_nettype wire
